@@ src/section_address_translator_assert.svh @@
// assertion macros shared by the section address translator modules
// both macros sample on clock and stay quiet while reset is high
`ifndef SECTION_ADDRESS_TRANSLATOR_ASSERT_SVH
`define SECTION_ADDRESS_TRANSLATOR_ASSERT_SVH

// same-cycle implication
`define SAT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/sat_pkg.sv @@
// ---------------------------------------------------------------------------
// sat_pkg
// types, constants and helpers shared by the section address translator
// ---------------------------------------------------------------------------
package sat_pkg;

   localparam int MAX_ENTRIES = 128;
   localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam int FUNC_W     = 2;
   localparam int SLOT_W     = 7;
   localparam int WORD_W     = 32;
   localparam int QUERY_W    = 64;
   localparam int COUNT_W    = 8;
   localparam int SIDX_W     = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SECTION_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_BASE    = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD,
      FUNC_ADDR_TO_SECT,
      FUNC_ADDR_TO_OFF,
      FUNC_OFF_TO_ADDR
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CALC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] va;
      logic [WORD_W-1:0] vs;
      logic [WORD_W-1:0] rs;
      logic [WORD_W-1:0] rp;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic load_wr;
      logic issue;
      logic capture;
      logic calc;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_load;
      logic empty_query;
      logic can_issue;
      logic cmp_hit;
      logic cmp_last;
      logic out_free;
   } sts_type;

   // section count clipped to the table depth
   function automatic logic [CNT_W-1:0] active_count(input logic [COUNT_W-1:0] cnt);
      if (int'(cnt) > MAX_ENTRIES) begin
         return CNT_W'(MAX_ENTRIES);
      end
      return CNT_W'(cnt);
   endfunction

endpackage

@@ src/sat_channel_if.sv @@
// ---------------------------------------------------------------------------
// sat request and response channels
// valid/ready channels carrying one request beat and one response beat
// ---------------------------------------------------------------------------
interface sat_req_if;
   import sat_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [SLOT_W-1:0]   entry_index;
   logic [WORD_W-1:0]   virt_addr;
   logic [WORD_W-1:0]   virt_size;
   logic [WORD_W-1:0]   raw_size;
   logic [WORD_W-1:0]   raw_ptr;
   logic [QUERY_W-1:0]  query_addr;

   modport source (
      output valid, func, entry_index, virt_addr, virt_size, raw_size, raw_ptr,
             query_addr,
      input  ready
   );

   modport sink (
      input  valid, func, entry_index, virt_addr, virt_size, raw_size, raw_ptr,
             query_addr,
      output ready
   );
endinterface

interface sat_rsp_if;
   import sat_pkg::*;

   logic                valid;
   logic                ready;
   logic                found;
   logic [SIDX_W-1:0]   section_index;
   logic [QUERY_W-1:0]  result_value;

   modport source (
      output valid, found, section_index, result_value,
      input  ready
   );

   modport sink (
      input  valid, found, section_index, result_value,
      output ready
   );
endinterface

@@ src/sat_ctrl.sv @@
// ---------------------------------------------------------------------------
// sat_ctrl
// sequencer for load, table scan, value calculation and response hand-off
// ---------------------------------------------------------------------------
`include "section_address_translator_assert.svh"

module sat_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sat_pkg::sts_type sts,
   output sat_pkg::cmd_type cmd
);
   import sat_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               if (sts.is_load) begin
                  cmd.load_wr = 1'b1;
                  state_in    = ST_DONE;
               end else if (sts.empty_query) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue = sts.can_issue && !sts.cmp_hit;
            if (sts.cmp_hit) begin
               cmd.capture = 1'b1;
               state_in    = ST_CALC;
            end else if (sts.cmp_last) begin
               state_in = ST_DONE;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `SAT_ASSERT_NOW(a_emit_needs_room, cmd.emit, sts.out_free, "response emitted into a full slot")
   `SAT_ASSERT_NEXT(a_hit_goes_calc, (state_ff == ST_SCAN) && sts.cmp_hit, state_ff == ST_CALC, "hit did not move to calc")
   `SAT_ASSERT_NEXT(a_start_leaves_idle, cmd.start, state_ff != ST_IDLE, "accepted beat left controller idle")

endmodule

@@ src/sat_dp.sv @@
// ---------------------------------------------------------------------------
// sat_dp
// section table, scan pointer, range compare, value adders and response slot
// ---------------------------------------------------------------------------
`include "section_address_translator_assert.svh"

module sat_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  sat_pkg::cmd_type                    cmd,
   output sat_pkg::sts_type                    sts,
   input  logic [sat_pkg::FUNC_W-1:0]          req_func,
   input  logic [sat_pkg::SLOT_W-1:0]          req_entry_index,
   input  logic [sat_pkg::WORD_W-1:0]          req_virt_addr,
   input  logic [sat_pkg::WORD_W-1:0]          req_virt_size,
   input  logic [sat_pkg::WORD_W-1:0]          req_raw_size,
   input  logic [sat_pkg::WORD_W-1:0]          req_raw_ptr,
   input  logic [sat_pkg::QUERY_W-1:0]         req_query_addr,
   input  logic                                csr_we,
   input  logic [sat_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sat_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_found,
   output logic [sat_pkg::SIDX_W-1:0]          rsp_section_index,
   output logic [sat_pkg::QUERY_W-1:0]         rsp_result_value
);
   import sat_pkg::*;

   // config registers
   logic [COUNT_W-1:0] count_ff;
   logic [QUERY_W-1:0] base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         base_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SECTION_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_IMAGE_BASE:    base_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // section table
   entry_type mem [MAX_ENTRIES];
   entry_type rd_data_ff;
   entry_type wr_entry;
   logic      slot_ok;

   assign wr_entry = '{va: req_virt_addr, vs: req_virt_size,
                       rs: req_raw_size, rp: req_raw_ptr};
   assign slot_ok  = int'(req_entry_index) < MAX_ENTRIES;

   // query context
   func_type           func_ff;
   logic [QUERY_W-1:0] q_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [CNT_W-1:0]   iss_ff;
   logic               rd_vld_ff;
   logic [ADDR_W-1:0]  rd_idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_wr && slot_ok) begin
         mem[ADDR_W'(req_entry_index)] <= wr_entry;
      end
      if (cmd.issue) begin
         rd_data_ff <= mem[iss_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         func_ff <= func_type'(req_func);
         q_ff    <= req_query_addr;
         n_ff    <= active_count(count_ff);
      end
      if (cmd.issue) begin
         rd_idx_ff <= iss_ff[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else if (cmd.start) begin
         iss_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.issue;
         if (cmd.issue) begin
            iss_ff <= iss_ff + CNT_W'(1);
         end
      end
   end

   // range compare on the registered entry
   logic [QUERY_W-1:0] va64;
   logic [QUERY_W-1:0] rp64;
   logic [QUERY_W-1:0] va_vs_end;
   logic [QUERY_W-1:0] lo_bound;
   logic [QUERY_W-1:0] hi_bound;
   logic               match;

   assign va64      = QUERY_W'(rd_data_ff.va);
   assign rp64      = QUERY_W'(rd_data_ff.rp);
   assign va_vs_end = va64 + QUERY_W'(rd_data_ff.vs);
   assign lo_bound  = (func_ff == FUNC_OFF_TO_ADDR) ? rp64 : va64;
   assign hi_bound  = lo_bound + QUERY_W'(rd_data_ff.rs);

   always_comb begin
      case (func_ff)
         FUNC_ADDR_TO_SECT: match = (q_ff >= va64) && (q_ff <= va_vs_end);
         FUNC_ADDR_TO_OFF:  match = (q_ff >= lo_bound) && (q_ff < hi_bound);
         FUNC_OFF_TO_ADDR:  match = (q_ff >= lo_bound) && (q_ff < hi_bound);
         default:           match = 1'b0;
      endcase
   end

   // hit capture and value build
   logic               hit_ff;
   logic [ADDR_W-1:0]  hit_idx_ff;
   logic [WORD_W-1:0]  hit_va_ff;
   logic [WORD_W-1:0]  hit_rp_ff;
   logic [QUERY_W-1:0] part_ff;
   logic [QUERY_W-1:0] part_in;
   logic [QUERY_W-1:0] value;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (cmd.start) begin
         hit_ff <= 1'b0;
      end else if (cmd.capture) begin
         hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hit_idx_ff <= rd_idx_ff;
         hit_va_ff  <= rd_data_ff.va;
         hit_rp_ff  <= rd_data_ff.rp;
      end
      if (cmd.calc) begin
         part_ff <= part_in;
      end
   end

   always_comb begin
      if (func_ff == FUNC_ADDR_TO_OFF) begin
         part_in = q_ff - QUERY_W'(hit_va_ff);
      end else if (hit_va_ff != '0) begin
         part_in = q_ff + QUERY_W'(hit_va_ff);
      end else begin
         part_in = q_ff + base_ff;
      end
   end

   always_comb begin
      case (func_ff)
         FUNC_ADDR_TO_OFF: value = part_ff + QUERY_W'(hit_rp_ff);
         FUNC_OFF_TO_ADDR: value = part_ff;
         default:          value = '0;
      endcase
   end

   // response slot
   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic [SIDX_W-1:0]  rsp_sidx_ff;
   logic [QUERY_W-1:0] rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_found_ff <= hit_ff;
         rsp_sidx_ff  <= hit_ff ? SIDX_W'(hit_idx_ff) : '0;
         rsp_value_ff <= hit_ff ? value : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_section_index = rsp_sidx_ff;
   assign rsp_result_value  = rsp_value_ff;

   // status
   assign sts.is_load     = func_type'(req_func) == FUNC_LOAD;
   assign sts.empty_query = (req_query_addr == '0) || (active_count(count_ff) == '0);
   assign sts.can_issue   = iss_ff < n_ff;
   assign sts.cmp_hit     = rd_vld_ff && match;
   assign sts.cmp_last    = rd_vld_ff && ((CNT_W'(rd_idx_ff) + CNT_W'(1)) == n_ff);
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;

   `SAT_ASSERT_NOW(a_issue_in_range, cmd.issue, iss_ff < n_ff, "read issued past section count")
   `SAT_ASSERT_NOW(a_read_in_range, rd_vld_ff, CNT_W'(rd_idx_ff) < n_ff, "compare on entry past section count")
   `SAT_ASSERT_NEXT(a_miss_is_zero, cmd.emit && !hit_ff, !rsp_found_ff && (rsp_sidx_ff == '0) && (rsp_value_ff == '0), "miss response not all zero")

endmodule

@@ src/section_address_translator.sv @@
// ---------------------------------------------------------------------------
// section_address_translator
// section table lookup: address to section, address to file offset, and
// file offset to address
// ---------------------------------------------------------------------------
// A load beat writes one 128-bit section record (virtual address, virtual
// size, raw size, raw pointer) into a single-port table of 128 entries and
// answers with an all-zero response. A query beat scans the records from
// entry 0 up to the section count, one table read per cycle, and stops at
// the first record whose range holds the query; the hitting entry is
// captured, its value is calculated, and the response is loaded into the
// output register once it is free; on a miss it is loaded after the last
// read. A zero query or a zero section count answers with a miss, like a
// load. One beat is worked on at a time; the response sits in an output
// register, so a new request beat is taken while the previous response
// still waits. Table entries are not cleared at reset: query only records
// that were loaded. The user must write the registers (section count, image
// base) through the csr port only while the block is idle; the block itself
// does not enforce this.
// ---------------------------------------------------------------------------
module section_address_translator (
   input  logic                            clock,
   input  logic                            reset,
   sat_req_if.sink                         req_chan,
   sat_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [sat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sat_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sat_pkg::*;

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: idle, scan, calc, done
   sat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table, compare, adders and response register
   sat_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_chan.func),
      .req_entry_index   (req_chan.entry_index),
      .req_virt_addr     (req_chan.virt_addr),
      .req_virt_size     (req_chan.virt_size),
      .req_raw_size      (req_chan.raw_size),
      .req_raw_ptr       (req_chan.raw_ptr),
      .req_query_addr    (req_chan.query_addr),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_found         (rsp_chan.found),
      .rsp_section_index (rsp_chan.section_index),
      .rsp_result_value  (rsp_chan.result_value)
   );

endmodule

@@ bench/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// section table lookups: loads, address to section, address to file offset
// and file offset to address, checked beat by beat against a scoreboard
// model of the table, under random idling on both channels
// ---------------------------------------------------------------------------
module tb;
   import sat_pkg::*;

   localparam longint RUN_LIMIT   = 64'd16_000_000;
   localparam int     HOLD_CYCLES = 300;
   localparam int     TAIL_CYCLES = 150;
   localparam int     NUM_PHASES  = 8;

   localparam logic [WORD_W-1:0]  ALL32 = {WORD_W{1'b1}};
   localparam logic [QUERY_W-1:0] ALL64 = {QUERY_W{1'b1}};

   typedef struct packed {
      func_type           func;
      logic [SLOT_W-1:0]  slot;
      logic [WORD_W-1:0]  va;
      logic [WORD_W-1:0]  vs;
      logic [WORD_W-1:0]  rs;
      logic [WORD_W-1:0]  rp;
      logic [QUERY_W-1:0] q;
   } request_type;

   typedef struct packed {
      logic               found;
      logic [SIDX_W-1:0]  sidx;
      logic [QUERY_W-1:0] value;
   } answer_type;

   // one directed beat, optionally preceded by a register update
   typedef struct packed {
      bit                  cfg;
      logic [COUNT_W-1:0]  cnt;
      logic [QUERY_W-1:0]  base;
      request_type         req;
      bit                  typed;
      answer_type          ans;
   } row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sat_req_if req_bus ();
   sat_rsp_if rsp_bus ();

   section_address_translator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // scoreboard copy of the section table and registers
   logic [WORD_W-1:0]  rec_va [MAX_ENTRIES];
   logic [WORD_W-1:0]  rec_vs [MAX_ENTRIES];
   logic [WORD_W-1:0]  rec_rs [MAX_ENTRIES];
   logic [WORD_W-1:0]  rec_rp [MAX_ENTRIES];
   logic [COUNT_W-1:0] cfg_count;
   logic [QUERY_W-1:0] cfg_base;

   answer_type pending_answers [$];
   int         bad_beats = 0;
   int         hold_asks = 0;   // bumped by the sender, served by the receiver
   bit         req_idle;
   bit         rsp_idle;

   // directed beats: empty table, load extremes, then lookups over four and
   // three records; typed answers only where they are obvious
   row_type dir_rows [22] = '{
      // empty table, nothing can match
      '{1'b0, 8'd0, 64'd0, '{FUNC_ADDR_TO_SECT, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         64'h1000}, 1'b1, '{1'b0, 7'd0, 64'd0}},
      '{1'b0, 8'd0, 64'd0, '{FUNC_OFF_TO_ADDR, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         ALL64}, 1'b1, '{1'b0, 7'd0, 64'd0}},
      // loads always answer all zero
      '{1'b0, 8'd0, 64'd0, '{FUNC_LOAD, 7'd0, 32'h1000, 32'h2000, 32'h1800, 32'h400,
         ALL64}, 1'b1, '{1'b0, 7'd0, 64'd0}},
      '{1'b0, 8'd0, 64'd0, '{FUNC_LOAD, 7'd1, 32'd0, ALL32, 32'h100, 32'h1_0000,
         64'd0}, 1'b1, '{1'b0, 7'd0, 64'd0}},
      '{1'b0, 8'd0, 64'd0, '{FUNC_LOAD, 7'd2, ALL32, ALL32, ALL32, ALL32,
         64'h5555_aaaa_5555_aaaa}, 1'b1, '{1'b0, 7'd0, 64'd0}},
      '{1'b0, 8'd0, 64'd0, '{FUNC_LOAD, 7'd3, 32'd0, 32'd0, 32'd0, 32'd0,
         64'd0}, 1'b1, '{1'b0, 7'd0, 64'd0}},
      '{1'b0, 8'd0, 64'd0, '{FUNC_LOAD, 7'd127, ALL32, ALL32, ALL32, ALL32,
         ALL64}, 1'b1, '{1'b0, 7'd0, 64'd0}},
      // four records, image base all ones; zero query never matches
      '{1'b1, 8'd4, ALL64, '{FUNC_ADDR_TO_SECT, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         64'd0}, 1'b1, '{1'b0, 7'd0, 64'd0}},
      // lower end and inclusive upper end of record 0
      '{1'b0, 8'd0, 64'd0, '{FUNC_ADDR_TO_SECT, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         64'h1000}, 1'b1, '{1'b1, 7'd0, 64'd0}},
      '{1'b0, 8'd0, 64'd0, '{FUNC_ADDR_TO_SECT, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         64'h3000}, 1'b1, '{1'b1, 7'd0, 64'd0}},
      '{1'b0, 8'd0, 64'd0, '{FUNC_ADDR_TO_SECT, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         64'h3001}, 1'b1, '{1'b1, 7'd1, 64'd0}},
      // range end past 32 bits must not wrap
      '{1'b0, 8'd0, 64'd0, '{FUNC_ADDR_TO_SECT, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         64'h1_0000_0000}, 1'b0, '{1'b0, 7'd0, 64'd0}},
      '{1'b0, 8'd0, 64'd0, '{FUNC_ADDR_TO_SECT, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         ALL64}, 1'b1, '{1'b0, 7'd0, 64'd0}},
      '{1'b0, 8'd0, 64'd0, '{FUNC_ADDR_TO_OFF, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         64'h1000}, 1'b0, '{1'b0, 7'd0, 64'd0}},
      '{1'b0, 8'd0, 64'd0, '{FUNC_ADDR_TO_OFF, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         64'h27ff}, 1'b0, '{1'b0, 7'd0, 64'd0}},
      // raw end is exclusive, and no other record covers it
      '{1'b0, 8'd0, 64'd0, '{FUNC_ADDR_TO_OFF, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         64'h2800}, 1'b1, '{1'b0, 7'd0, 64'd0}},
      '{1'b0, 8'd0, 64'd0, '{FUNC_OFF_TO_ADDR, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         64'h400}, 1'b0, '{1'b0, 7'd0, 64'd0}},
      // zero virtual address: image base is added and the sum wraps
      '{1'b0, 8'd0, 64'd0, '{FUNC_OFF_TO_ADDR, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         64'h1_0000}, 1'b0, '{1'b0, 7'd0, 64'd0}},
      '{1'b0, 8'd0, 64'd0, '{FUNC_OFF_TO_ADDR, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         64'h1_ffff_fffd}, 1'b0, '{1'b0, 7'd0, 64'd0}},
      '{1'b0, 8'd0, 64'd0, '{FUNC_ADDR_TO_OFF, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         64'h1_ffff_fffd}, 1'b0, '{1'b0, 7'd0, 64'd0}},
      // three records, image base zero
      '{1'b1, 8'd3, 64'd0, '{FUNC_OFF_TO_ADDR, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         64'h1_0080}, 1'b0, '{1'b0, 7'd0, 64'd0}},
      '{1'b0, 8'd0, 64'd0, '{FUNC_ADDR_TO_OFF, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0,
         ALL64}, 1'b1, '{1'b0, 7'd0, 64'd0}}
   };

   // records searched by a query: count clipped to the table depth
   function automatic int searched_records();
      return (int'(cfg_count) > MAX_ENTRIES) ? MAX_ENTRIES : int'(cfg_count);
   endfunction

   // expected answer for one beat; a load also updates the table copy
   function automatic answer_type lookup_section(request_type r);
      answer_type a;
      logic [QUERY_W-1:0] va, vs, rs, rp;
      a = '0;
      if (r.func == FUNC_LOAD) begin
         rec_va[r.slot] = r.va;
         rec_vs[r.slot] = r.vs;
         rec_rs[r.slot] = r.rs;
         rec_rp[r.slot] = r.rp;
      end else if (r.q != '0) begin
         for (int i = 0; i < searched_records() && !a.found; i++) begin
            // range ends in 64 bits so 32-bit sums never wrap
            va = QUERY_W'(rec_va[i]);
            vs = QUERY_W'(rec_vs[i]);
            rs = QUERY_W'(rec_rs[i]);
            rp = QUERY_W'(rec_rp[i]);
            case (r.func)
               FUNC_ADDR_TO_SECT: begin
                  a.found = (r.q >= va) && (r.q <= va + vs);
               end
               FUNC_ADDR_TO_OFF: begin
                  a.found = (r.q >= va) && (r.q < va + rs);
                  a.value = r.q - va + rp;
               end
               default: begin
                  a.found = (r.q >= rp) && (r.q < rp + rs);
                  a.value = (va != '0) ? r.q + va : r.q + cfg_base;
               end
            endcase
            if (a.found) begin
               a.sidx = SIDX_W'(i);
            end
         end
         if (!a.found) begin
            a = '0;
         end
      end
      return a;
   endfunction

   // idle stretch: mostly short, now and then long
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return $urandom_range(1, 3);
      end
      if (roll < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 40);
   endfunction

   // random section record; many land in one crowded region so that
   // ranges overlap and first-match order matters
   function automatic request_type make_load(logic [SLOT_W-1:0] slot);
      request_type r;
      r.func = FUNC_LOAD;
      r.slot = slot;
      r.q    = {$urandom, $urandom};
      r.va   = $urandom;
      r.vs   = $urandom;
      r.rs   = $urandom;
      r.rp   = $urandom;
      case ($urandom_range(0, 7))
         0, 1, 2: begin
            r.va = 32'h0001_0000 + 32'(slot) * 32'h200 + $urandom_range(0, 255);
            r.vs = $urandom_range(0, 32'h400);
            r.rs = $urandom_range(0, 32'h400);
            r.rp = 32'h400 + 32'(slot) * 32'h180 + $urandom_range(0, 127);
         end
         3: begin
            // zero virtual address, mapped through the image base
            r.va = '0;
            r.vs = $urandom_range(0, 32'h1000);
            r.rs = $urandom_range(0, 32'h1000);
            r.rp = 32'h8000_0000 + $urandom_range(0, 32'hffff);
         end
         4: begin
            r.va = $urandom_range(0, 1) ? ALL32 : '0;
            r.vs = $urandom_range(0, 1) ? ALL32 : '0;
            r.rs = $urandom_range(0, 1) ? ALL32 : '0;
            r.rp = $urandom_range(0, 1) ? ALL32 : '0;
         end
         default: ;
      endcase
      return r;
   endfunction

   // present one request beat, predict its answer once accepted
   task automatic offer(request_type r, bit typed, answer_type typed_ans);
      answer_type a;
      int gap;
      gap = (req_idle && $urandom_range(0, 2) == 0) ? idle_len() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= r.func;
      req_bus.entry_index <= r.slot;
      req_bus.virt_addr   <= r.va;
      req_bus.virt_size   <= r.vs;
      req_bus.raw_size    <= r.rs;
      req_bus.raw_ptr     <= r.rp;
      req_bus.query_addr  <= r.q;
      do @(posedge clock); while (!req_bus.ready);
      a = lookup_section(r);
      pending_answers.push_back(typed ? typed_ans : a);
   endtask

   // stop offering and wait for every outstanding answer
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   // block is idle here; write both registers on back-to-back edges
   task automatic set_regs(logic [CSR_DATA_W-1:0] count_word,
                           logic [CSR_DATA_W-1:0] base);
      drain();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_SECTION_COUNT;
      csr_wdata <= count_word;
      @(posedge clock);
      cfg_count = count_word[COUNT_W-1:0];
      csr_index <= CSR_IMAGE_BASE;
      csr_wdata <= base;
      @(posedge clock);
      cfg_base = base;
      csr_we <= 1'b0;
   endtask

   // response side: check each accepted beat, throttle ready
   initial begin : rsp_side
      answer_type want;
      answer_type got;
      int stall;
      int holds_taken;
      stall       = 0;
      holds_taken = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.found, rsp_bus.section_index, rsp_bus.result_value};
            if (pending_answers.size() == 0) begin
               $display(
                  "%0t: response beat with nothing expected: found %0b index %0d value %h",
                  $time, got.found, got.sidx, got.value);
               bad_beats++;
            end else begin
               want = pending_answers.pop_front();
               if (got !== want) begin
                  $display(
                  "%0t: expected found %0b index %0d value %h, got found %0b index %0d value %h",
                  $time, want.found, want.sidx, want.value,
                  got.found, got.sidx, got.value);
                  bad_beats++;
               end
            end
         end
         // long hold-off on request, otherwise random stalls when enabled
         if (hold_asks != holds_taken) begin
            holds_taken++;
            stall = HOLD_CYCLES;
         end else if (stall == 0 && rsp_idle && $urandom_range(0, 3) == 0) begin
            stall = idle_len();
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      request_type r;
      logic [CSR_DATA_W-1:0] word;
      logic [QUERY_W-1:0] lo, size, off;
      logic [COUNT_W-1:0] cnt;
      int n, k, sel, beats;

      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_index           <= CSR_SECTION_COUNT;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.func        <= FUNC_LOAD;
      req_bus.entry_index <= '0;
      req_bus.virt_addr   <= '0;
      req_bus.virt_size   <= '0;
      req_bus.raw_size    <= '0;
      req_bus.raw_ptr     <= '0;
      req_bus.query_addr  <= '0;
      cfg_count = '0;
      cfg_base  = '0;
      req_idle  = 1'b1;
      rsp_idle  = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, register updates folded into the rows
      foreach (dir_rows[i]) begin
         if (dir_rows[i].cfg) begin
            word = {$urandom, $urandom};
            word[COUNT_W-1:0] = dir_rows[i].cnt;
            set_regs(word, dir_rows[i].base);
         end
         offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].ans);
      end

      // fill every slot so any section count is safe to search
      for (int s = 0; s < MAX_ENTRIES; s++) begin
         offer(make_load(SLOT_W'(s)), 1'b0, '0);
      end

      // random phases over several register settings, extremes included
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: cnt = 8'd1;
            1: cnt = 8'd4;
            2: cnt = 8'd128;
            3: cnt = 8'd255;   // saturates to the table depth
            4: cnt = 8'd0;
            5: cnt = 8'($urandom_range(5, 40));
            6: cnt = 8'd2;
            default: cnt = 8'd200;
         endcase
         word = {$urandom, $urandom};
         word[COUNT_W-1:0] = cnt;
         case (p % 3)
            0: set_regs(word, ALL64);
            1: set_regs(word, '0);
            default: set_regs(word, {$urandom, $urandom});
         endcase
         req_idle = (p % 3 != 1);
         rsp_idle = (p % 4 != 2);
         // full-depth scans are slow, so those phases stay short
         beats = (cnt >= 8'd100) ? 120 : 300;

         for (int j = 0; j < beats; j++) begin
            if (j == beats / 3) begin
               hold_asks++;
            end
            if (j == 2 * beats / 3) begin
               drain();
            end
            r = make_load(SLOT_W'($urandom_range(0, MAX_ENTRIES - 1)));
            if ($urandom_range(0, 99) >= 15) begin
               r.func = func_type'($urandom_range(1, 3));
               n      = searched_records();
               sel    = $urandom_range(0, 15);
               if (n > 0 && sel < 11) begin
                  // aim at the edges and inside of one live record
                  k = $urandom_range(0, n - 1);
                  case (r.func)
                     FUNC_ADDR_TO_SECT: begin
                        lo   = QUERY_W'(rec_va[k]);
                        size = QUERY_W'(rec_vs[k]) + QUERY_W'(1);
                     end
                     FUNC_ADDR_TO_OFF: begin
                        lo   = QUERY_W'(rec_va[k]);
                        size = QUERY_W'(rec_rs[k]);
                     end
                     default: begin
                        lo   = QUERY_W'(rec_rp[k]);
                        size = QUERY_W'(rec_rs[k]);
                     end
                  endcase
                  off = (size == '0) ? '0 : {$urandom, $urandom} % size;
                  case (sel)
                     0: r.q = lo;
                     1: r.q = lo + size - 1;
                     2: r.q = lo + size;
                     3: r.q = lo - 1;
                     default: r.q = lo + off;
                  endcase
               end else if (sel == 11) begin
                  r.q = '0;
               end else if (sel == 12) begin
                  r.q = QUERY_W'($urandom_range(0, 32'h3_0000));
               end
            end
            offer(r, 1'b0, '0);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (bad_beats == 0) begin
         $display("section_address_translator: match");
      end else begin
         $display("section_address_translator: mismatch");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("section_address_translator: mismatch");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+src
src/sat_pkg.sv
src/sat_channel_if.sv
src/sat_ctrl.sv
src/sat_dp.sv
src/section_address_translator.sv
bench/tb.sv
